@@ src/isrs_pkg.sv @@
// ----------------------------------------------------------------------------
// isrs_pkg
// Types and codes shared by the integer set range sum unit.
// ----------------------------------------------------------------------------
package isrs_pkg;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2,
        ST_QUERY    = 2'd3
    } isrs_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } isrs_state_t;

    typedef struct packed {
        logic               func;
        logic signed [63:0] add_value;
        logic signed [63:0] range_low;
        logic signed [63:0] range_high;
    } isrs_in_t;

    typedef struct packed {
        logic signed [63:0] range_total;
        logic [1:0]         add_status;
    } isrs_out_t;

endpackage

@@ src/isrs_mem.sv @@
// ----------------------------------------------------------------------------
// isrs_mem
// Single-port-write, single-port-read member table with a registered read.
// ----------------------------------------------------------------------------
module isrs_mem #(
    parameter int CAPACITY = 256,
    parameter int ADDR_W   = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [63:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [63:0]       rd_data
);

    logic [63:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/isrs_scan.sv @@
// ----------------------------------------------------------------------------
// isrs_scan
// Sequencer: walks the filled part of the table once per item, matching for
// adds and accumulating in-range members for queries, then appends on insert.
// ----------------------------------------------------------------------------
module isrs_scan
    import isrs_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int ADDR_W   = 8,
    parameter int CNT_W    = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  isrs_in_t          in_data,
    output logic              res_valid,
    input  logic              res_take,
    output isrs_out_t         res_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [63:0]       wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [63:0]       rd_data
);

    isrs_state_t        state_reg, state_next;
    isrs_in_t           item_reg;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;
    logic signed [63:0] acc_reg, acc_next;
    logic               accept;
    logic               issue;
    logic               in_range;
    logic               table_full;
    logic               do_insert;

    assign accept     = in_valid && in_ready;
    assign issue      = (state_reg == S_SCAN) && (ptr_reg < count_reg);
    assign table_full = (count_reg == CNT_W'(CAPACITY));
    assign in_range   = ($signed(rd_data) >= item_reg.range_low) &&
                        ($signed(rd_data) <= item_reg.range_high);
    assign do_insert  = (item_reg.func == FUNC_ADD) && !found_reg && !table_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        rd_en     = issue;
        rd_addr   = ptr_reg[ADDR_W-1:0];
        res_valid = (state_reg == S_FINISH);
        wr_en     = (state_reg == S_FINISH) && res_take && do_insert;
        wr_addr   = count_reg[ADDR_W-1:0];
        wr_data   = item_reg.add_value;
        if (item_reg.func == FUNC_QUERY)
        begin
            res_data.range_total = acc_reg;
            res_data.add_status  = ST_QUERY;
        end
        else
        begin
            res_data.range_total = '0;
            if (found_reg)
            begin
                res_data.add_status = ST_PRESENT;
            end
            else if (table_full)
            begin
                res_data.add_status = ST_FULL;
            end
            else
            begin
                res_data.add_status = ST_INSERTED;
            end
        end
    end

    // datapath
    always_comb
    begin
        ptr_next   = ptr_reg;
        pend_next  = issue;
        found_next = found_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        if (accept)
        begin
            ptr_next   = '0;
            found_next = 1'b0;
            acc_next   = '0;
        end
        if (issue)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        if (pend_reg)
        begin
            if (rd_data == item_reg.add_value)
            begin
                found_next = 1'b1;
            end
            if (in_range)
            begin
                acc_next = acc_reg + $signed(rd_data);
            end
        end
        if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            acc_reg   <= acc_next;
        end
    end

    // hold the accepted item for the whole walk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("member count beyond capacity");

    a_write_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_FINISH) && !pend_reg && !rd_en)
        else $error("table write overlaps the walk");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN) && (ptr_reg == '0))
        else $error("accepted item did not start a walk");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SCAN))
        else $error("read data returned outside the walk");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance the member count");

endmodule

@@ src/integer_set_range_sum_unit.sv @@
// An accepted item walks the stored members (at most CAPACITY) in the scan
// state, reading one table entry per cycle through the single read port, then
// waits in the finish state until the output register is free and loads it.
// One item at a time: the input is ready only while the sequencer is idle.
// A held output stalls the finished item and the input.
// Reset: the member count and all control clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// integer_set_range_sum_unit
// Set of distinct signed 64-bit members with insert and inclusive range sum.
// ----------------------------------------------------------------------------
module integer_set_range_sum_unit
    import isrs_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  isrs_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output isrs_out_t out_data
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic              res_valid;
    logic              res_take;
    isrs_out_t         res_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [63:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [63:0]       rd_data;
    logic              out_valid_reg, out_valid_next;
    isrs_out_t         out_data_reg;

    isrs_mem #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    isrs_scan #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // output slot frees when empty or when its transfer completes
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
